FILE: design/lkv_pkg.sv
// Shared types and constants for the linear key/value table.
// Field widths, request and status codes, and the controller command bundle.
// No dependencies.
package lkv_pkg;

  localparam int TYPE_W      = 3;
  localparam int KEY_PORT_W  = 32;
  localparam int VAL_PORT_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;

  localparam int DEPTH_DEF   = 16;
  localparam int KEY_W_DEF   = 32;
  localparam int VAL_W_DEF   = 32;

  localparam logic [TYPE_W-1:0] REQ_LOOKUP  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_GET_INS = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_WRITE   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DELETE  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic capture;  // latch request and match vector
    logic commit;   // apply update and load the result register
  } lkv_cmd_t;

endpackage

FILE: design/linear_key_value_table.sv
// Linear key/value table: small associative map kept in insertion order.
// A request is captured with its match vector when accepted in idle, then committed from the
// execute state once the result register is free; the result is held until out_ready takes it.
// No new request is taken until the current one commits: a match step, then an update step.
// A waiting result still lets one more request in; its update then holds until the result leaves.
// Reset clears the entry count and handshake state; cells need no clearing pass.
module linear_key_value_table import lkv_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_W_DEF,
  parameter int VALUE_WIDTH = VAL_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TYPE_W-1:0]     in_req_type,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [VAL_PORT_W-1:0] in_write_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VAL_PORT_W-1:0] out_read_value,
  output logic                  out_found,
  output logic [STATUS_W-1:0]   out_status,
  output logic [COUNT_W-1:0]    out_entry_count
);

  localparam int CountW = $clog2(TABLE_DEPTH + 1);

  lkv_cmd_t              cmd;
  logic [CountW-1:0]     fill_count;
  logic [TABLE_DEPTH-1:0] match_vec;

  // Controller: accept a request in idle, commit it from the execute state once
  // the result register is free, then return to idle.
  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: compare the request key with every live cell at accept,
  // then apply lookup/insert/write/delete/clear on commit.
  lkv_datapath #(
    .Depth  (TABLE_DEPTH),
    .KeyW   (KEY_WIDTH),
    .ValW   (VALUE_WIDTH),
    .CountW (CountW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_write_value  (in_write_value),
    .out_read_value  (out_read_value),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .fill_count      (fill_count),
    .match_vec       (match_vec)
  );

`ifndef SYNTHESIS
  // the entry count never runs past the table depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count <= CountW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // stored keys are unique, so a committed request matches at most one cell
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0(match_vec))
    else $error("request matched more than one entry");

  // one request in flight: accepting a request drops ready for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in flight");

  // a commit always leaves a result waiting on the output
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed request produced no result");
`endif

endmodule

FILE: design/lkv_ctrl.sv
// Controller state machine for the linear key/value table.
// Depends on lkv_pkg for the command bundle.
module lkv_ctrl import lkv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lkv_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the request until the result register can take it
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/lkv_datapath.sv
// Datapath for the linear key/value table: entry cells, parallel key match,
// insert at the tail, delete shift and the result register. Depends on lkv_pkg.
module lkv_datapath import lkv_pkg::*; #(
  parameter int Depth  = DEPTH_DEF,
  parameter int KeyW   = KEY_W_DEF,
  parameter int ValW   = VAL_W_DEF,
  parameter int CountW = $clog2(Depth + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lkv_cmd_t              cmd,
  input  logic [TYPE_W-1:0]     in_req_type,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [VAL_PORT_W-1:0] in_write_value,
  output logic [VAL_PORT_W-1:0] out_read_value,
  output logic                  out_found,
  output logic [STATUS_W-1:0]   out_status,
  output logic [COUNT_W-1:0]    out_entry_count,
  output logic [CountW-1:0]     fill_count,
  output logic [Depth-1:0]      match_vec
);

  localparam int IdxW = $clog2(Depth);

  logic [KeyW-1:0]     key_cell_r [Depth];
  logic [ValW-1:0]     val_cell_r [Depth];
  logic [KeyW-1:0]     key_nxt    [Depth];
  logic [ValW-1:0]     val_nxt    [Depth];
  logic [CountW-1:0]   fill_r;
  logic [CountW-1:0]   fill_nxt;
  logic [TYPE_W-1:0]   type_r;
  logic [KeyW-1:0]     key_r;
  logic [ValW-1:0]     wval_r;
  logic [Depth-1:0]    match_r;
  logic [Depth-1:0]    match_nxt;

  logic                hit;
  logic                full;
  logic                is_write;
  logic [IdxW-1:0]     pos;
  logic [ValW-1:0]     rd_val;
  logic [ValW-1:0]     rv;
  logic [STATUS_W-1:0] status;

  logic [VAL_PORT_W-1:0] out_read_value_r;
  logic                  out_found_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_entry_count_r;

  // compare the incoming key against every live cell
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match_nxt[i] = (CountW'(i) < fill_r) && (key_cell_r[i] == KeyW'(in_key));
    end
  end

  always_comb begin
    // keys are unique, so at most one match bit is set: plain OR encodes it
    hit    = |match_r;
    pos    = '0;
    rd_val = '0;
    for (int i = 0; i < Depth; i++) begin
      if (match_r[i]) begin
        pos    = pos | IdxW'(i);
        rd_val = rd_val | val_cell_r[i];
      end
    end
    full     = (fill_r == CountW'(Depth));
    is_write = (type_r == REQ_WRITE);
    key_nxt  = key_cell_r;
    val_nxt  = val_cell_r;
    fill_nxt = fill_r;
    rv       = '0;
    status   = ST_OK;
    case (type_r)
      REQ_GET_INS, REQ_WRITE: begin
        if (hit) begin
          if (is_write) begin
            for (int i = 0; i < Depth; i++) begin
              if (match_r[i]) val_nxt[i] = wval_r;
            end
            rv = wval_r;
          end else begin
            rv = rd_val;
          end
        end else if (full) begin
          status = ST_FULL;
        end else begin
          for (int i = 0; i < Depth; i++) begin
            if (CountW'(i) == fill_r) begin
              key_nxt[i] = key_r;
              val_nxt[i] = is_write ? wval_r : '0;
            end
          end
          rv       = is_write ? wval_r : '0;
          fill_nxt = fill_r + CountW'(1);
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          // close the gap: every cell from the match upward takes its neighbor
          for (int i = 0; i < Depth - 1; i++) begin
            if (IdxW'(i) >= pos) begin
              key_nxt[i] = key_cell_r[i+1];
              val_nxt[i] = val_cell_r[i+1];
            end
          end
          fill_nxt = fill_r - CountW'(1);
        end else begin
          status = ST_ABSENT;
        end
      end
      REQ_CLEAR: begin
        fill_nxt = '0;
      end
      default: begin
        rv = rd_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.commit) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r  <= in_req_type;
      key_r   <= KeyW'(in_key);
      wval_r  <= ValW'(in_write_value);
      match_r <= match_nxt;
    end
    if (cmd.commit) begin
      key_cell_r        <= key_nxt;
      val_cell_r        <= val_nxt;
      out_read_value_r  <= VAL_PORT_W'(rv);
      out_found_r       <= hit;
      out_status_r      <= status;
      out_entry_count_r <= COUNT_W'(fill_nxt);
    end
  end

  assign out_read_value  = out_read_value_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;
  assign fill_count      = fill_r;
  assign match_vec       = match_r;

endmodule

FILE: verif/lkv_table_checker.sv
// Checker for the linear key/value table: watches both request and response channels.
// Keeps its own copy of the table, predicts each response and compares it field by field.
// Depends on lkv_pkg for field widths, request codes and status codes.
module lkv_table_checker import lkv_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TYPE_W-1:0]     in_req_type,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [VAL_PORT_W-1:0] in_write_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [VAL_PORT_W-1:0] out_read_value,
  input  logic                  out_found,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [COUNT_W-1:0]    out_entry_count,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_PORT_W-1:0] read_value;
    logic                  found;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    entry_count;
  } table_response_t;

  logic [KEY_PORT_W-1:0] key_cells [TABLE_DEPTH];
  logic [VAL_PORT_W-1:0] value_cells [TABLE_DEPTH];
  int                    entries;
  table_response_t       predicted_responses [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    entries       = 0;
  end

  // Apply one request to the shadow table and return the response it should give.
  function automatic table_response_t table_apply(input logic [TYPE_W-1:0] kind,
                                                  input logic [KEY_PORT_W-1:0] key,
                                                  input logic [VAL_PORT_W-1:0] wval);
    table_response_t resp;
    int              hit;
    hit  = -1;
    resp = '0;
    for (int i = 0; i < entries; i++) begin
      if (hit < 0 && key_cells[i] == key) hit = i;
    end
    case (kind)
      REQ_GET_INS, REQ_WRITE: begin
        if (hit >= 0) begin
          if (kind == REQ_WRITE) value_cells[hit] = wval;
          resp.read_value = value_cells[hit];
        end else if (entries >= TABLE_DEPTH) begin
          resp.status = ST_FULL;
        end else begin
          key_cells[entries]   = key;
          value_cells[entries] = (kind == REQ_WRITE) ? wval : '0;
          resp.read_value      = value_cells[entries];
          entries++;
        end
      end
      REQ_DELETE: begin
        if (hit >= 0) begin
          // close the gap: every later entry moves down one place
          for (int i = hit; i + 1 < entries; i++) begin
            key_cells[i]   = key_cells[i + 1];
            value_cells[i] = value_cells[i + 1];
          end
          entries--;
        end else begin
          resp.status = ST_ABSENT;
        end
      end
      REQ_CLEAR: entries = 0;
      default: begin
        if (hit >= 0) resp.read_value = value_cells[hit];
      end
    endcase
    resp.found       = (hit >= 0);
    resp.entry_count = COUNT_W'(entries);
    return resp;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    table_response_t want;
    if (!rst_n) begin
      entries = 0;
      predicted_responses.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_responses.size() == 0) begin
          fail_count++;
          $display("%0t: response with none expected, expected nothing, actual %0h/%0b/%0d/%0d",
                   $time, out_read_value, out_found, out_status, out_entry_count);
        end else begin
          want = predicted_responses.pop_front();
          check_field("read_value", want.read_value, out_read_value);
          check_field("found", want.found, out_found);
          check_field("status", want.status, out_status);
          check_field("entry_count", want.entry_count, out_entry_count);
        end
      end
      if (in_valid && in_ready)
        predicted_responses.push_back(table_apply(in_req_type, in_key, in_write_value));
    end
    pending_count = predicted_responses.size();
  end

endmodule

FILE: verif/linear_key_value_table_tb.sv
// Top of the testbench for the linear key/value table.
// Drives requests and response back-pressure, runs the idling phases and prints the verdict.
// Depends on lkv_pkg, linear_key_value_table and lkv_table_checker.
module linear_key_value_table_tb import lkv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes 5 to 7 are unused and behave as a lookup.
  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam int RANDOM_PER_PHASE = 350;
  localparam int KEY_POOL_SIZE    = 20;  // more keys than cells, so the table fills up
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TYPE_W-1:0]     in_req_type = '0;
  logic [KEY_PORT_W-1:0] in_key = '0;
  logic [VAL_PORT_W-1:0] in_write_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VAL_PORT_W-1:0] out_read_value;
  logic                  out_found;
  logic [STATUS_W-1:0]   out_status;
  logic [COUNT_W-1:0]    out_entry_count;

  int fail_count;
  int pending_count;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles = 0;

  logic [KEY_PORT_W-1:0] key_pool [KEY_POOL_SIZE];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  linear_key_value_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  lkv_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  // Back-pressure: drop out_ready at random, at the rate the current phase asks for.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until the block takes it. Idle cycles are
  // inserted first, so valid only drops when a gap is wanted; back-to-back requests
  // keep valid high and just swap the payload at the falling edge.
  task automatic send_request(input logic [TYPE_W-1:0] kind,
                              input logic [KEY_PORT_W-1:0] key,
                              input logic [VAL_PORT_W-1:0] wval);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_key         <= key;
    in_write_value <= wval;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every outstanding response has come back.
  task automatic drain_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Random traffic: mostly keys from a small pool so hits, updates, deletes and a
  // full table are common; a few fully random keys add misses and bit coverage.
  task automatic run_random(input int count);
    logic [TYPE_W-1:0]     kind;
    logic [KEY_PORT_W-1:0] key;
    logic [VAL_PORT_W-1:0] wval;
    int                    pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 25)      kind = REQ_LOOKUP;
      else if (pick < 45) kind = REQ_GET_INS;
      else if (pick < 70) kind = REQ_WRITE;
      else if (pick < 90) kind = REQ_DELETE;
      else if (pick < 93) kind = REQ_CLEAR;
      else                kind = TYPE_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      else                         key = $urandom;
      case ($urandom_range(9))
        0:       wval = '0;
        1:       wval = '1;
        default: wval = $urandom;
      endcase
      send_request(kind, key, wval);
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    // Hold reset, then release it at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests, no idling: empty table, extreme keys and values,
    // every request code, a full table, deletes at head and tail, clears.
    send_request(REQ_LOOKUP, '0, '1);             // lookup on empty table
    send_request(REQ_DELETE, '0, '0);             // delete of an absent key
    send_request(REQ_WRITE, '0, '1);              // write inserts a new key
    send_request(REQ_GET_INS, '1, 32'h5A5A_5A5A); // get-or-insert adds zero value
    send_request(REQ_LOOKUP, '0, '0);             // lookup hit
    send_request(REQ_WRITE, '1, 32'h1234_5678);   // write replaces present value
    send_request(REQ_UNUSED_HI, '0, '0);          // unused code acts as lookup
    send_request(REQ_GET_INS, '0, '0);            // get-or-insert on present key
    for (int i = 1; i <= 14; i++)                 // fill every remaining cell
      send_request(REQ_WRITE, KEY_PORT_W'(i), ~VAL_PORT_W'(i));
    send_request(REQ_WRITE, 32'h100, 32'h1);      // insert refused: table full
    send_request(REQ_GET_INS, 32'h101, '0);       // same via get-or-insert
    send_request(REQ_DELETE, '0, '0);             // delete first entry, shift all
    send_request(REQ_DELETE, 32'd14, '0);         // delete last entry
    send_request(REQ_CLEAR, '1, '0);              // clear with key present
    send_request(REQ_CLEAR, '1, '0);              // clear on empty table
    drain_responses();

    // Random phases; drain between them so the sender pauses with nothing in flight.
    run_random(RANDOM_PER_PHASE);
    drain_responses();

    sender_idle_pct = 60;
    run_random(RANDOM_PER_PHASE);
    drain_responses();

    sender_idle_pct    = 0;
    receiver_stall_pct = 60;
    run_random(RANDOM_PER_PHASE);
    drain_responses();

    sender_idle_pct    = 7;
    receiver_stall_pct = 7;
    run_random(RANDOM_PER_PHASE);
    drain_responses();

    // Let any stray response show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lkv_pkg.sv
design/lkv_ctrl.sv
design/lkv_datapath.sv
design/linear_key_value_table.sv
verif/lkv_table_checker.sv
verif/linear_key_value_table_tb.sv
